/* rtl/piecewise_linear_curve_lookup_unit_assert.svh */
// Assertion macros for the curve lookup unit.
// Used by the front and top-level modules; no other dependencies.
`ifndef PIECEWISE_LINEAR_CURVE_LOOKUP_UNIT_ASSERT_SVH
`define PIECEWISE_LINEAR_CURVE_LOOKUP_UNIT_ASSERT_SVH
// implication checked on every clock edge outside reset
`define PLC_ASSERT_IMP(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) \
    else $error("assertion failed");
// implication whose consequent is checked in the next cycle
`define PLC_ASSERT_NXT(lbl, clk, rstn, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) \
    else $error("assertion failed");
`endif

/* rtl/plcl_pkg.sv */
// Shared types and constants for the curve lookup unit.
// No dependencies.
`timescale 1ns / 1ps
package plcl_pkg;
  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_ADD     = 2'd1,
    OP_FORWARD = 2'd2,
    OP_INVERSE = 2'd3
  } op_t;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [31:0] arg_x;
    logic signed [31:0] arg_y;
    logic signed [31:0] key;
  } cmd_t;

  // interpolation job: base + trunc(sign * mag * off / span)
  typedef struct packed {
    logic               interp;
    logic signed [31:0] base;
    logic               neg;
    logic [32:0]        mag;
    logic [32:0]        off;
    logic [32:0]        span;
    logic               ok;
    logic               full;
  } job_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               ok;
    logic               table_full;
  } res_t;
endpackage

/* rtl/plcl_front.sv */
// Front end: breakpoint table, command handling and segment search.
// Depends on plcl_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "piecewise_linear_curve_lookup_unit_assert.svh"
module plcl_front import plcl_pkg::*; #(
  parameter int NUM_POINTS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic cmd_valid,
  output logic cmd_ready,
  input  cmd_t cmd,
  output logic job_valid,
  input  logic job_ready,
  output job_t job
);
  localparam int IW = (NUM_POINTS > 1) ? $clog2(NUM_POINTS) : 1;
  localparam int CW = $clog2(NUM_POINTS + 1);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RD0  = 6'b000010,
    S_RDL  = 6'b000100,
    S_SCAN = 6'b001000,
    S_EVAL = 6'b010000,
    S_OUT  = 6'b100000
  } st_t;

  logic signed [31:0] xs [NUM_POINTS];
  logic signed [31:0] ys [NUM_POINTS];

  st_t st_r, st_nxt;
  logic [IW-1:0] head_r, head_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] i_r, i_nxt;
  cmd_t cmd_r;
  job_t job_r, job_nxt;
  logic signed [31:0] fx_r, fy_r, lx_r, ly_r, ax_r, ay_r;
  logic signed [31:0] rx_r, ry_r;
  logic [IW-1:0] ra;
  logic wr_en;
  logic [IW-1:0] wa;
  logic found;
  logic signed [32:0] k33, ak, bk, av, bv;

  function automatic logic [IW-1:0] slot(input logic [IW-1:0] h, input logic [CW-1:0] i);
    logic [IW:0] s;
    s = {1'b0, h} + (IW+1)'(i);
    if (s >= (IW+1)'(NUM_POINTS)) s = s - (IW+1)'(NUM_POINTS);
    return s[IW-1:0];
  endfunction

  always_comb begin
    ra = slot(head_r, '0);
    case (st_r)
      S_IDLE: ra = slot(head_r, '0);
      S_RD0:  ra = slot(head_r, cnt_r - CW'(1));
      default: ra = slot(head_r, i_r);
    endcase
  end

  always_ff @(posedge clk) begin
    rx_r <= xs[ra];
    ry_r <= ys[ra];
    if (wr_en) begin
      xs[wa] <= cmd_r.arg_x;
      ys[wa] <= cmd_r.arg_y;
    end
  end

  assign k33 = 33'(cmd_r.key);
  assign ak = (cmd_r.opcode == OP_FORWARD) ? 33'(ax_r) : 33'(ay_r);
  assign bk = (cmd_r.opcode == OP_FORWARD) ? 33'(rx_r) : 33'(ry_r);
  assign av = (cmd_r.opcode == OP_FORWARD) ? 33'(ay_r) : 33'(ax_r);
  assign bv = (cmd_r.opcode == OP_FORWARD) ? 33'(ry_r) : 33'(rx_r);
  assign found = (k33 >= ak) && (k33 <= bk);

  always_comb begin
    logic signed [32:0] d;
    st_nxt   = st_r;
    head_nxt = head_r;
    cnt_nxt  = cnt_r;
    i_nxt    = i_r;
    job_nxt  = job_r;
    wr_en    = 1'b0;
    wa       = slot(head_r, cnt_r);
    d        = '0;
    case (st_r)
      S_IDLE: if (cmd_valid) st_nxt = S_RD0;
      S_RD0: begin
        job_nxt = '0;
        st_nxt  = S_OUT;
        case (op_t'(cmd_r.opcode))
          OP_CLEAR: begin
            cnt_nxt = '0; head_nxt = '0;
          end
          OP_ADD: begin
            if (cnt_r == CW'(NUM_POINTS)) job_nxt.full = 1'b1;
            else begin
              wr_en = 1'b1;
              if (cnt_r == '0) wa = head_r;
              else if (cmd_r.arg_x < rx_r) begin
                head_nxt = (head_r == '0) ? IW'(NUM_POINTS - 1) : head_r - IW'(1);
                wa = head_nxt;
              end
              cnt_nxt = cnt_r + CW'(1);
              job_nxt.ok = 1'b1;
            end
          end
          default: begin
            if (cnt_r == CW'(1)) begin
              job_nxt.ok = 1'b1;
              job_nxt.base = (cmd_r.opcode == OP_FORWARD) ? ry_r : rx_r;
            end else if (cnt_r != '0) st_nxt = S_RDL;
          end
        endcase
      end
      S_RDL: begin
        i_nxt = CW'(1);
        st_nxt = S_SCAN;
        // forward lookups clamp to the end points before any search
        if (cmd_r.opcode == OP_FORWARD) begin
          if (cmd_r.key < fx_r) begin
            job_nxt.ok = 1'b1; job_nxt.base = fy_r; st_nxt = S_OUT;
          end else if (cmd_r.key > rx_r) begin
            job_nxt.ok = 1'b1; job_nxt.base = ry_r; st_nxt = S_OUT;
          end
        end
      end
      S_SCAN: st_nxt = S_EVAL;
      S_EVAL: begin
        if (found) begin
          job_nxt.ok = 1'b1;
          job_nxt.base = av[31:0];
          d = bv - av;
          job_nxt.neg = d[32];
          job_nxt.mag = d[32] ? 33'(-d) : d;
          job_nxt.off = 33'(k33 - ak);
          job_nxt.span = 33'(bk - ak);
          job_nxt.interp = 1'b1;
          st_nxt = S_OUT;
        end else if (i_r == cnt_r - CW'(1)) begin
          st_nxt = S_OUT;
          if (cmd_r.opcode == OP_INVERSE) begin
            if (cmd_r.key < fy_r) begin
              job_nxt.ok = 1'b1; job_nxt.base = fx_r;
            end else if (cmd_r.key > ly_r) begin
              job_nxt.ok = 1'b1; job_nxt.base = lx_r;
            end
          end
        end else begin
          i_nxt = i_r + CW'(1);
          st_nxt = S_SCAN;
        end
      end
      S_OUT: if (job_ready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; head_r <= '0; cnt_r <= '0; i_r <= '0;
    end else begin
      st_r <= st_nxt; head_r <= head_nxt; cnt_r <= cnt_nxt; i_r <= i_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == S_IDLE && cmd_valid) cmd_r <= cmd;
    job_r <= job_nxt;
    if (st_r == S_RD0) begin
      fx_r <= rx_r; fy_r <= ry_r; ax_r <= rx_r; ay_r <= ry_r;
    end
    if (st_r == S_RDL) begin
      lx_r <= rx_r; ly_r <= ry_r;
    end
    if (st_r == S_EVAL) begin
      ax_r <= rx_r; ay_r <= ry_r;
    end
  end

  always_comb begin
    job = job_r;
    if (!job_r.interp && !job_r.ok) job.base = '0;
  end

  assign cmd_ready = (st_r == S_IDLE);
  assign job_valid = (st_r == S_OUT);

  `PLC_ASSERT_IMP(a_cnt_range, clk, rst_n, 1'b1, cnt_r <= CW'(NUM_POINTS))
  `PLC_ASSERT_IMP(a_full_no_ok, clk, rst_n, job_valid && job.full, !job.ok)
  `PLC_ASSERT_NXT(a_stall_hold, clk, rst_n, job_valid && !job_ready, job_valid && $stable(job))
endmodule

/* rtl/plcl_queue.sv */
// Two-entry queue between the front end and the divider back end.
// Depends on plcl_pkg.
`timescale 1ns / 1ps
module plcl_queue import plcl_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  job_t in_job,
  output logic out_valid,
  input  logic out_ready,
  output job_t out_job
);
  job_t mem [2];
  logic wp_r, rp_r;
  logic [1:0] n_r;
  logic push, pop;

  assign in_ready  = (n_r != 2'd2);
  assign out_valid = (n_r != 2'd0);
  assign push = in_valid && in_ready;
  assign pop  = out_valid && out_ready;
  assign out_job = mem[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem[wp_r] <= in_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; n_r <= '0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      n_r <= n_r + 2'(push) - 2'(pop);
    end
  end
endmodule

/* rtl/plcl_back.sv */
// Back end: serial muldiv (mag*off/span) and result register.
// Depends on plcl_pkg.
`timescale 1ns / 1ps
module plcl_back import plcl_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic job_valid,
  output logic job_ready,
  input  job_t job,
  output logic res_valid,
  input  logic res_ready,
  output res_t res
);
  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_MUL  = 4'b0010,
    B_DIV  = 4'b0100,
    B_OUT  = 4'b1000
  } bst_t;

  bst_t st_r, st_nxt;
  job_t j_r;
  logic [65:0] prod_r;
  logic [33:0] rem_r;
  logic [65:0] q_r;
  logic [6:0] k_r;
  logic [33:0] trial;
  res_t res_r;

  assign trial = {rem_r[32:0], prod_r[65]} - {1'b0, j_r.span};

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      B_IDLE: if (job_valid) st_nxt = (job.interp && job.span != '0) ? B_MUL : B_OUT;
      B_MUL:  st_nxt = B_DIV;
      B_DIV:  if (k_r == 7'd65) st_nxt = B_OUT;
      B_OUT:  if (res_ready) st_nxt = B_IDLE;
      default: st_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= B_IDLE;
    else st_r <= st_nxt;
  end

  always_ff @(posedge clk) begin
    case (st_r)
      B_IDLE: if (job_valid) begin
        j_r <= job;
        res_r.value <= job.base;
        res_r.ok <= job.ok;
        res_r.table_full <= job.full;
      end
      B_MUL: begin
        prod_r <= j_r.mag * j_r.off;
        rem_r <= '0; q_r <= '0; k_r <= '0;
      end
      B_DIV: begin
        if (!trial[33]) begin
          rem_r <= trial; q_r <= {q_r[64:0], 1'b1};
        end else begin
          rem_r <= {rem_r[32:0], prod_r[65]}; q_r <= {q_r[64:0], 1'b0};
        end
        prod_r <= {prod_r[64:0], 1'b0};
        k_r <= k_r + 7'd1;
        if (k_r == 7'd65) begin
          res_r.value <= j_r.neg ? j_r.base - 32'({q_r[30:0], ~trial[33]})
                                 : j_r.base + 32'({q_r[30:0], ~trial[33]});
        end
      end
      default: ;
    endcase
  end

  assign job_ready = (st_r == B_IDLE);
  assign res_valid = (st_r == B_OUT);
  assign res = res_r;
endmodule

/* rtl/piecewise_linear_curve_lookup_unit.sv */
// Piecewise-linear curve lookup: table front end, queue, divider back end.
// Depends on plcl_pkg, plcl_front, plcl_queue, plcl_back and the assert header.
// Front end: lookups scan the table segments in order; interpolating lookups then pass through the back end.
// The front end takes no new command until its previous job has been handed to the queue.
// Back end: each interpolation runs a multiply, 66 divide steps and an output state; no new job until taken.
// Reset: rst_n synchronous active low clears count, head and control; table contents undefined.
`timescale 1ns / 1ps
`include "piecewise_linear_curve_lookup_unit_assert.svh"
module piecewise_linear_curve_lookup_unit import plcl_pkg::*; #(
  parameter int NUM_POINTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // arg_x[31:0], arg_y[63:32], key[95:64]
  input  logic [1:0]  in_tuser,   // opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // value
  output logic [1:0]  out_tuser   // ok[0], table_full[1]
);
  cmd_t cmd;
  job_t fj, qj;
  logic fv, fr, qv, qr;
  res_t res;

  assign cmd.opcode = in_tuser;
  assign cmd.arg_x  = in_tdata[31:0];
  assign cmd.arg_y  = in_tdata[63:32];
  assign cmd.key    = in_tdata[95:64];

  plcl_front #(.NUM_POINTS(NUM_POINTS)) u_front (
    .clk, .rst_n, .cmd_valid(in_tvalid), .cmd_ready(in_tready), .cmd,
    .job_valid(fv), .job_ready(fr), .job(fj));
  plcl_queue u_queue (
    .clk, .rst_n, .in_valid(fv), .in_ready(fr), .in_job(fj),
    .out_valid(qv), .out_ready(qr), .out_job(qj));
  plcl_back u_back (
    .clk, .rst_n, .job_valid(qv), .job_ready(qr), .job(qj),
    .res_valid(out_tvalid), .res_ready(out_tready), .res);

  assign out_tdata = res.value;
  assign out_tuser = {res.table_full, res.ok};

  `PLC_ASSERT_IMP(a_out_flags, clk, rst_n, out_tvalid, !(res.ok && res.table_full))
  `PLC_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, $stable(out_tdata))
  `PLC_ASSERT_IMP(a_full_zero, clk, rst_n, out_tvalid && res.table_full, res.value == 32'sd0)
endmodule
